FILE: rtl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
`default_nettype none

package ptt_pkg;

  // Field widths of a transaction
  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned PeriodW = 31;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned StatusW = 3;

  // Stream packing: input tdata holds id, period, now; output tdata holds id
  localparam int unsigned InIdLsb     = 0;
  localparam int unsigned InPeriodLsb = InIdLsb + IdW;
  localparam int unsigned InNowLsb    = InPeriodLsb + PeriodW;
  localparam int unsigned InTdataW    = ((InNowLsb + TimeW + 7) / 8) * 8;
  localparam int unsigned OutTdataW   = IdW;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FUNC_SET  = 2'd0,
    FUNC_KILL = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_FIRED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_ADDED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_KILLED   = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_NONE     = 3'd6
  } status_e;

  // Table write data source
  typedef enum logic [1:0] {
    WR_NEW   = 2'd0,
    WR_FIRE  = 2'd1,
    WR_SHIFT = 2'd2
  } wr_sel_e;

  // Result id source
  typedef enum logic [1:0] {
    ID_IN   = 2'd0,
    ID_PEND = 2'd1,
    ID_ZERO = 2'd2
  } id_sel_e;

  // One table entry
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   last_fire;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_set;
    logic    pend_clr;
    logic    out_load;
    status_e out_status;
    id_sel_e out_id_sel;
    logic    out_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_e func;
    logic  at_end;
    logic  shift_done;
    logic  full;
    logic  id_match;
    logic  expired;
    logic  pend_valid;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ptt_dp.sv
// Datapath of the timer table: entry memory, scan index, count and result register.
`default_nettype none

module ptt_dp
  import ptt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic [FuncW-1:0]   in_func_i,
  input  wire logic [IdW-1:0]     in_id_i,
  input  wire logic [PeriodW-1:0] in_period_i,
  input  wire logic [TimeW-1:0]   in_now_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [StatusW-1:0]      out_status_o,
  output logic [IdW-1:0]          out_id_o,
  output logic                    out_last_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // Captured transaction
  func_e              func_q;
  logic [IdW-1:0]     id_q;
  logic [PeriodW-1:0] period_q;
  logic [TimeW-1:0]   now_q;

  // Scan control
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_plus;

  // Pending fired id, held until we know whether it is the final one
  logic           pend_valid_q, pend_valid_d;
  logic [IdW-1:0] pend_id_q;

  // Memory and registered read
  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_q;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [TimeW-1:0] elapsed;

  // Result register
  logic           out_valid_q;
  status_e        out_status_q;
  logic [IdW-1:0] out_id_q;
  logic           out_last_q;
  logic [IdW-1:0] out_id_sel;

  assign idx_plus = idx_q + CW'(1);
  assign rd_addr  = cmd_i.rd_next ? idx_plus[AW-1:0] : idx_q[AW-1:0];
  assign wr_addr  = idx_q[AW-1:0];
  assign elapsed  = now_q - rd_q.last_fire;

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q   <= func_e'(in_func_i);
      id_q     <= in_id_i;
      period_q <= in_period_i;
      now_q    <= in_now_i;
    end
  end

  // Index and count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_plus;
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    pend_valid_d = pend_valid_q;
    if (cmd_i.pend_set) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_set) begin
      pend_id_q <= rd_q.id;
    end
  end

  // Write data select
  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_NEW:   wr_data = '{id: id_q, period: period_q, last_fire: now_q};
      WR_FIRE:  wr_data = '{id: rd_q.id, period: rd_q.period, last_fire: now_q};
      WR_SHIFT: wr_data = rd_q;
      default:  wr_data = rd_q;
    endcase
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result id select
  always_comb begin
    unique case (cmd_i.out_id_sel)
      ID_IN:   out_id_sel = id_q;
      ID_PEND: out_id_sel = pend_id_q;
      ID_ZERO: out_id_sel = '0;
      default: out_id_sel = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_id_q     <= out_id_sel;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_last_o   = out_last_q;

  // Status to the controller
  always_comb begin
    sts_o.func       = func_q;
    sts_o.at_end     = (idx_q == cnt_q);
    sts_o.shift_done = (idx_plus >= cnt_q);
    sts_o.full       = (cnt_q == DepthC);
    sts_o.id_match   = (rd_q.id == id_q);
    sts_o.expired    = (elapsed > TimeW'(rd_q.period));
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

FILE: rtl/ptt_ctrl.sv
// Controller of the timer table: sequences search, shift, scan and result emission.
`default_nettype none

module ptt_ctrl
  import ptt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_WR = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  status_e fin_q, fin_d;

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;

    unique case (state_q)
      // Wait for a transaction
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_RD;
        end
      end

      // End of table check, else read the entry at the index
      S_RD: begin
        unique case (sts_i.func)
          FUNC_SET: begin
            if (sts_i.at_end) begin
              if (sts_i.full) begin
                fin_d = ST_FULL;
              end else begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_sel  = WR_NEW;
                cmd_o.cnt_inc = 1'b1;
                fin_d         = ST_ADDED;
              end
              state_d = S_FIN;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_CMP;
            end
          end
          FUNC_KILL: begin
            if (sts_i.at_end) begin
              fin_d   = ST_NOTFOUND;
              state_d = S_FIN;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_CMP;
            end
          end
          FUNC_TICK: begin
            if (sts_i.at_end) begin
              state_d = S_FIN;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_CMP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // Evaluate the entry just read
      S_CMP: begin
        unique case (sts_i.func)
          FUNC_SET: begin
            if (sts_i.id_match) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WR_NEW;
              fin_d        = ST_UPDATED;
              state_d      = S_FIN;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_RD;
            end
          end
          FUNC_KILL: begin
            if (sts_i.id_match) begin
              fin_d   = ST_KILLED;
              state_d = S_SH_RD;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_RD;
            end
          end
          FUNC_TICK: begin
            if (!sts_i.expired) begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_RD;
            end else if (!sts_i.pend_valid || sts_i.out_free) begin
              // Release the previous fired id as a non-final result
              if (sts_i.pend_valid) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_FIRED;
                cmd_o.out_id_sel = ID_PEND;
                cmd_o.out_last   = 1'b0;
              end
              cmd_o.pend_set = 1'b1;
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = WR_FIRE;
              cmd_o.idx_inc  = 1'b1;
              state_d        = S_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // Close the gap after a kill
      S_SH_RD: begin
        if (sts_i.shift_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SH_RD;
      end

      // Final result of the transaction
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.pend_clr = 1'b1;
          if (sts_i.func == FUNC_TICK) begin
            if (sts_i.pend_valid) begin
              cmd_o.out_status = ST_FIRED;
              cmd_o.out_id_sel = ID_PEND;
            end else begin
              cmd_o.out_status = ST_NONE;
              cmd_o.out_id_sel = ID_ZERO;
            end
          end else begin
            cmd_o.out_status = fin_q;
            cmd_o.out_id_sel = ID_IN;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= ST_NONE;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/periodic_timer_table.sv
// Periodic timer table: set, kill and tick over an ordered table of timers.
// A set updates the entry with a matching id, or adds one at the end unless the table is full;
// a kill searches for the id and on a hit shifts the later entries down; a tick scans every
// entry and gives one result per fired timer, or a single none result if no timer fired.
// Throughput: one transaction at a time; the next one is accepted in the cycle after the final result loads.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending result.
`default_nettype none

module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,  // timer_id[15:0], period_ms[46:16],
                                                    // now_ms[110:47], zero pad
  input  wire logic [FuncW-1:0]     s_axis_tuser,  // func[1:0]
  // Result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,  // fired_id[15:0]
  output logic [StatusW-1:0]        m_axis_tuser,  // status[2:0]
  output logic                      m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_func_i    (s_axis_tuser),
    .in_id_i      (s_axis_tdata[InIdLsb +: IdW]),
    .in_period_i  (s_axis_tdata[InPeriodLsb +: PeriodW]),
    .in_now_i     (s_axis_tdata[InNowLsb +: TimeW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_id_o     (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire
